// ===== hdl/npcs_pkg.sv =====
// Shared types, constants and the color distance function for the palette search.
package npcs_pkg;

	localparam int PALETTE_SIZE = 256;
	// Only as many entries as the index field can name are searched.
	localparam int WALK_LEN     = (PALETTE_SIZE < 256) ? PALETTE_SIZE : 256;
	localparam int ADDR_W       = $clog2(PALETTE_SIZE);
	localparam int WALK_W       = $clog2(WALK_LEN);
	localparam int COLOR_W      = 15;
	localparam int DIST_W       = 10;
	localparam int MAX_DIST     = 744;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic        command;
		logic [7:0]  entry_index;
		logic [15:0] color;
	} req_t;

	typedef struct packed {
		logic [7:0]        best_index;
		logic [DIST_W-1:0] best_distance;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] data;
	} pal_wr_t;

	function automatic logic [4:0] abs5(input logic [4:0] a, input logic [4:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Channels are scaled by eight, so scale the summed 5-bit differences once.
	function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		logic [6:0] sum;
		sum = 7'(abs5(a[14:10], b[14:10])) + 7'(abs5(a[9:5], b[9:5]))
			+ 7'(abs5(a[4:0], b[4:0]));
		return {sum, 3'b000};
	endfunction

endpackage

// ===== hdl/nearest_palette_color_search.sv =====
// Top level: command port, palette walk sequencer and running minimum.
//
// Usage: drive req and pulse start while busy is low; the transaction is
// taken at that clock edge. A write command (command = 0) stores color[14:0]
// at entry_index in the same edge and never raises busy, so writes may be
// issued every cycle while busy is low; indexes beyond the palette are
// dropped. A query (command = 1) raises busy and reads one palette entry
// per cycle from the palette memory, which has one write and one read
// port, comparing each against the query color. Each entry passes
// through the registered memory read into the running minimum, and the
// result register is loaded once the last entry is compared. busy falls
// in the cycle rsp_valid is high, so the next command is taken at the
// edge that takes the result. rsp_valid is a one-cycle strobe; the
// receiver cannot stall and must take rsp in that cycle. Ties go to the
// lowest palette index.
// Reset: all palette entries read as zero, no query is in flight and
// rsp_valid is low. No clearing pass is needed: valid bits reset at once.
module nearest_palette_color_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  npcs_pkg::req_t req,
	output logic           rsp_valid,
	output npcs_pkg::rsp_t rsp
);
	import npcs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [WALK_W-1:0] LAST_IDX = WALK_W'(WALK_LEN - 1);

	logic [1:0]         state_q;
	logic [WALK_W-1:0]  ctr_q;
	logic [COLOR_W-1:0] qcolor_q;
	logic               rd_vld_s1;
	logic               rd_last_s1;
	logic [WALK_W-1:0]  rd_idx_s1;
	logic [DIST_W-1:0]  best_dist_q;
	logic [WALK_W-1:0]  best_idx_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	pal_wr_t            pal_wr;
	logic [COLOR_W-1:0] pal_rd_data;
	logic               accept;
	logic [DIST_W-1:0]  cur_dist;
	logic               take;
	logic [DIST_W-1:0]  nxt_dist;
	logic [WALK_W-1:0]  nxt_idx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		pal_wr.en   = accept && (req.command == CMD_WRITE)
			&& (32'(req.entry_index) < PALETTE_SIZE);
		pal_wr.addr = ADDR_W'(req.entry_index);
		pal_wr.data = req.color[COLOR_W-1:0];
	end

	npcs_palette u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_addr (ADDR_W'(ctr_q)),
		.rd_data (pal_rd_data)
	);

	// Entry zero always seeds the minimum; later entries must be strictly closer.
	always_comb begin
		cur_dist = color_dist(qcolor_q, pal_rd_data);
		take     = (rd_idx_s1 == '0) || (cur_dist < best_dist_q);
		nxt_dist = take ? cur_dist : best_dist_q;
		nxt_idx  = take ? rd_idx_s1 : best_idx_q;
	end

	always_ff @(posedge clk) begin
		if (accept && (req.command == CMD_QUERY)) begin
			qcolor_q <= req.color[COLOR_W-1:0];
		end
		rd_idx_s1 <= ctr_q;
		if (rd_vld_s1) begin
			best_dist_q <= nxt_dist;
			best_idx_q  <= nxt_idx;
		end
		if (rd_vld_s1 && rd_last_s1) begin
			rsp_q.best_index    <= 8'(nxt_idx);
			rsp_q.best_distance <= nxt_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1   <= (state_q == ST_WALK);
			rd_last_s1  <= (ctr_q == LAST_IDX);
			rsp_valid_q <= rd_vld_s1 && rd_last_s1;
			case (state_q)
				ST_IDLE: begin
					ctr_q <= '0;
					if (accept && (req.command == CMD_QUERY)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (ctr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						ctr_q <= ctr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last entry is compared this cycle; result lands next edge
					state_q <= ST_IDLE;
					ctr_q   <= '0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !busy)
		else $error("result strobe while a query is still walking");

	a_rsp_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("result strobe longer than one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.command == CMD_QUERY) |=> busy)
		else $error("accepted query did not raise busy");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.best_distance) <= MAX_DIST))
		else $error("distance out of range");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.command == CMD_WRITE) |=> !busy && !rsp_valid)
		else $error("palette write started a walk or produced a result");

endmodule

// ===== hdl/npcs_palette.sv =====
// Palette memory with per-entry valid bits; unwritten entries read as zero.
module npcs_palette (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npcs_pkg::pal_wr_t             wr,
	input  logic [npcs_pkg::ADDR_W-1:0]   rd_addr,
	output logic [npcs_pkg::COLOR_W-1:0]  rd_data
);
	import npcs_pkg::*;

	logic [COLOR_W-1:0]      mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] vld_q;
	logic [COLOR_W-1:0]      dat_q;
	logic                    dat_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		dat_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			dat_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			dat_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = dat_vld_q ? dat_q : '0;

endmodule
